// ----- rtl/core/pffs_pkg.sv -----
// ----------------------------------------------------------------------------
// pffs_pkg: shared types and constants of the page frame free stack
// Field widths, action and status codes, controller states and the default
// values of the top level parameters.
// ----------------------------------------------------------------------------
package pffs_pkg;

   // Default parameter values
   localparam int PAGE_SHIFT_DEFAULT  = 12;
   localparam int STACK_DEPTH_DEFAULT = 4096;
   localparam int ADDR_BITS_DEFAULT   = 48;

   // Fixed field widths of the streaming channels
   localparam int FIELD_W     = 48;
   localparam int TYPE_W      = 8;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int PAGES_W     = 13;
   localparam int REQ_DATA_W  = 104;
   localparam int RSP_DATA_W  = 64;

   // Configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [0:0] REG_USABLE_TYPE = 1'b0;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_OOM     = 2'd1,
      ST_FULL    = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_POP   = 2'd1,
      S_SETUP = 2'd2,
      S_PUSH  = 2'd3
   } state_type;

endpackage

// ----- rtl/core/page_frame_free_stack_core.sv -----
// ----------------------------------------------------------------------------
// page_frame_free_stack_core: physical page-frame allocator on a free stack
// Keeps free page numbers on a last-in-first-out stack held in one RAM and
// answers alloc, free and add-region transactions with one response each.
// ----------------------------------------------------------------------------
// Operation: one request transaction is handled at a time. A free writes the
// RAM on the accepting edge and loads its response register on that edge; an
// alloc starts the registered RAM read of the top entry on acceptance and
// answers from state S_POP; an unknown or rejected request answers on the
// accepting edge. An add-region decodes the region in S_IDLE and S_SETUP,
// then walks it in S_PUSH one page per cycle, pushing each page number
// through the single RAM write port (page zero is skipped, not pushed). The
// walk answers when the region end is reached or the stack is full. The
// response sits in an output register, so the next request is accepted as
// soon as the previous response is taken or in the same cycle it is taken.
// The free stack RAM needs no clearing after reset: only entries below the stack count are ever read.
// ----------------------------------------------------------------------------
module page_frame_free_stack_core #(
   parameter int PAGE_SHIFT  = pffs_pkg::PAGE_SHIFT_DEFAULT,
   parameter int STACK_DEPTH = pffs_pkg::STACK_DEPTH_DEFAULT,
   parameter int ADDR_BITS   = pffs_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [47:0] address, [95:48] region_length, [103:96] region_type
   input  logic [pffs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] action
   input  logic [pffs_pkg::ACTION_W-1:0]     req_tuser,

   // Response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [47:0] page_address, [60:48] pages_added, [63:61] zero
   output logic [pffs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [pffs_pkg::STATUS_W-1:0]     rsp_tuser,

   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pffs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pffs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pffs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int FW  = pffs_pkg::FIELD_W;
   localparam int PW  = pffs_pkg::PAGES_W;
   // Effective address width seen through the 48-bit fields
   localparam int AW  = (ADDR_BITS < FW) ? ADDR_BITS : FW;
   // Stored page number width
   localparam int PNW = (AW > PAGE_SHIFT) ? AW - PAGE_SHIFT : 1;
   // Region walk width: the region top can reach twice the page number range
   localparam int TW  = PNW + 1;
   localparam int SPACE_BITS = (ADDR_BITS > PAGE_SHIFT) ? ADDR_BITS - PAGE_SHIFT : 0;
   localparam bit CLAMP = (ADDR_BITS <= FW);
   localparam int IW  = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);

   localparam logic [FW-1:0] AMASK   = {FW{1'b1}} >> (FW - AW);
   localparam logic [TW-1:0] SPACE   = CLAMP ? (TW'(1) << SPACE_BITS) : '0;
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   // ------------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------------
   logic [pffs_pkg::TYPE_W-1:0] usable_type_ff;
   logic                        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == pffs_pkg::REG_USABLE_TYPE);

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_type_ff <= '0;
      end else if (csr_write) begin
         usable_type_ff <= csr_pwdata[pffs_pkg::TYPE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == pffs_pkg::REG_USABLE_TYPE)
                       ? {{(pffs_pkg::CSR_DATA_W - pffs_pkg::TYPE_W){1'b0}}, usable_type_ff}
                       : '0;

   // ------------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------------
   logic [FW-1:0]              req_addr;
   logic [FW-1:0]              req_len;
   logic [pffs_pkg::TYPE_W-1:0] req_type;
   logic [FW-1:0]              addr_pn_full;
   logic [FW-1:0]              len_pn_full;
   logic [PNW-1:0]             addr_pn;
   logic [PNW-1:0]             len_pn;
   logic [PAGE_SHIFT:0]        off_sum;
   logic                       req_acc;

   // Mask addresses to the configured address space
   assign req_addr = req_tdata[FW-1:0] & AMASK;
   assign req_len  = req_tdata[2*FW-1:FW] & AMASK;
   assign req_type = req_tdata[2*FW+pffs_pkg::TYPE_W-1:2*FW];

   assign addr_pn_full = req_addr >> PAGE_SHIFT;
   assign len_pn_full  = req_len >> PAGE_SHIFT;
   assign addr_pn      = addr_pn_full[PNW-1:0];
   assign len_pn       = len_pn_full[PNW-1:0];
   // Offset bits of base and length: their sum may carry one more page
   assign off_sum      = {1'b0, req_addr[PAGE_SHIFT-1:0]} + {1'b0, req_len[PAGE_SHIFT-1:0]};

   assign req_acc = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------------
   pffs_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [PNW-1:0]       a_pn_ff, a_pn_in;
   logic [PNW-1:0]       l_pn_ff, l_pn_in;
   logic                 a_nz_ff, a_nz_in;
   logic                 carry_ff, carry_in;
   logic [TW-1:0]        p_ff, p_in;
   logic [TW-1:0]        top_ff, top_in;
   logic [PW-1:0]        added_ff, added_in;
   logic                 any_ff, any_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]        rsp_addr_ff, rsp_addr_in;
   pffs_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [PW-1:0]        rsp_added_ff, rsp_added_in;

   // RAM ports
   logic                 ram_wr_en;
   logic [IW-1:0]        ram_wr_addr;
   logic [PNW-1:0]       ram_wr_data;
   logic                 ram_rd_en;
   logic [IW-1:0]        ram_rd_addr;
   logic [PNW-1:0]       ram_rd_data;

   logic [CW-1:0]        count_dec;
   logic                 stack_full;
   logic                 type_match;
   logic [TW-1:0]        top_raw;
   logic [FW-1:0]        pop_addr;
   logic                 walk_end;

   assign count_dec  = count_ff - 1'b1;
   assign stack_full = (count_ff == DEPTH_C);
   assign type_match = (req_type == usable_type_ff);
   assign top_raw    = {1'b0, a_pn_ff} + {1'b0, l_pn_ff} + TW'(carry_ff);
   assign pop_addr   = (FW'(ram_rd_data) << PAGE_SHIFT) & AMASK;
   // Stop the region walk at its top, or when a real page meets a full stack
   assign walk_end   = (p_ff >= top_ff) || ((p_ff != '0) && stack_full);

   // Take a request only when idle and the response register is free
   assign req_tready = (state_ff == pffs_pkg::S_IDLE) && (!rsp_valid_ff || rsp_tready);

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pffs_pkg::S_IDLE: begin
            if (req_acc) begin
               case (req_tuser)
                  pffs_pkg::ACT_ALLOC: begin
                     if (count_ff != '0) begin
                        state_in = pffs_pkg::S_POP;
                     end
                  end
                  pffs_pkg::ACT_ADD: begin
                     if (type_match) begin
                        state_in = pffs_pkg::S_SETUP;
                     end
                  end
                  default: begin
                     state_in = pffs_pkg::S_IDLE;
                  end
               endcase
            end
         end
         pffs_pkg::S_POP: begin
            state_in = pffs_pkg::S_IDLE;
         end
         pffs_pkg::S_SETUP: begin
            state_in = pffs_pkg::S_PUSH;
         end
         pffs_pkg::S_PUSH: begin
            if (walk_end) begin
               state_in = pffs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pffs_pkg::S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath and outputs
   // ------------------------------------------------------------------------
   always_comb begin
      count_in      = count_ff;
      a_pn_in       = a_pn_ff;
      l_pn_in       = l_pn_ff;
      a_nz_in       = a_nz_ff;
      carry_in      = carry_ff;
      p_in          = p_ff;
      top_in        = top_ff;
      added_in      = added_ff;
      any_in        = any_ff;
      // Drop the held response once it is taken
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_added_in  = rsp_added_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[IW-1:0];
      ram_wr_data   = p_ff[PNW-1:0];
      ram_rd_en     = 1'b0;
      ram_rd_addr   = count_dec[IW-1:0];

      case (state_ff)
         pffs_pkg::S_IDLE: begin
            if (req_acc) begin
               rsp_addr_in  = '0;
               rsp_added_in = '0;
               case (req_tuser)
                  pffs_pkg::ACT_ALLOC: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pffs_pkg::ST_OOM;
                     end else begin
                        // Read the top entry; data arrives next cycle
                        ram_rd_en = 1'b1;
                        count_in  = count_dec;
                     end
                  end
                  pffs_pkg::ACT_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (req_addr == '0) begin
                        rsp_status_in = pffs_pkg::ST_IGNORED;
                     end else if (stack_full) begin
                        rsp_status_in = pffs_pkg::ST_FULL;
                     end else begin
                        ram_wr_en     = 1'b1;
                        ram_wr_data   = addr_pn;
                        count_in      = count_ff + 1'b1;
                        rsp_status_in = pffs_pkg::ST_DONE;
                     end
                  end
                  pffs_pkg::ACT_ADD: begin
                     if (type_match) begin
                        a_pn_in  = addr_pn;
                        l_pn_in  = len_pn;
                        a_nz_in  = |req_addr[PAGE_SHIFT-1:0];
                        carry_in = off_sum[PAGE_SHIFT];
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pffs_pkg::ST_IGNORED;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pffs_pkg::ST_IGNORED;
                  end
               endcase
            end
         end
         pffs_pkg::S_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = pop_addr;
            rsp_status_in = pffs_pkg::ST_DONE;
         end
         pffs_pkg::S_SETUP: begin
            // Round the base up and the top down to whole pages
            p_in     = {1'b0, a_pn_ff} + TW'(a_nz_ff);
            top_in   = (CLAMP && (top_raw > SPACE)) ? SPACE : top_raw;
            added_in = '0;
            any_in   = 1'b0;
         end
         pffs_pkg::S_PUSH: begin
            any_in = 1'b1;
            if (p_ff >= top_ff) begin
               // An empty region on the first step is ignored
               rsp_valid_in  = 1'b1;
               rsp_status_in = any_ff ? pffs_pkg::ST_DONE : pffs_pkg::ST_IGNORED;
               rsp_added_in  = added_ff;
            end else if (p_ff == '0) begin
               // Skip page zero: never a valid page
               p_in = p_ff + 1'b1;
            end else if (stack_full) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pffs_pkg::ST_FULL;
               rsp_added_in  = added_ff;
            end else begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
               p_in      = p_ff + 1'b1;
               // Saturate the reported page count
               added_in  = (&added_ff) ? added_ff : added_ff + 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pffs_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_pn_ff       <= a_pn_in;
      l_pn_ff       <= l_pn_in;
      a_nz_ff       <= a_nz_in;
      carry_ff      <= carry_in;
      p_ff          <= p_in;
      top_ff        <= top_in;
      added_ff      <= added_in;
      any_ff        <= any_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_added_ff  <= rsp_added_in;
   end

   // ------------------------------------------------------------------------
   // Free stack storage
   // ------------------------------------------------------------------------
   pffs_ram #(
      .WIDTH (PNW),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Response channel
   // ------------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pffs_pkg::RSP_DATA_W - FW - PW){1'b0}}, rsp_added_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- rtl/core/pffs_ram.sv -----
// ----------------------------------------------------------------------------
// pffs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pffs_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
